// ===== sv/kvwp_pkg.sv =====
package kvwp_pkg;

   localparam int STAGE_BYTES = 64;
   localparam int BEAT_BYTES  = 32;
   localparam int KEY_MAX     = 30;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_CHUNK  = 1'b1;

   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_CONT  = 2'd1;
   localparam logic [1:0] MODE_FIRST = 2'd2;

   localparam logic [1:0] KIND_MORE = 2'd0;
   localparam logic [1:0] KIND_LAST = 2'd1;
   localparam logic [1:0] KIND_RESP = 2'd2;

   typedef logic [BEAT_BYTES-1:0][7:0]  half_bytes_type;
   typedef logic [STAGE_BYTES-1:0][7:0] stage_bytes_type;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  request_meta;
      logic [4:0]  key_len;
      logic [10:0] value_len;
      logic [63:0] record_base;
      logic [1:0]  array_mode;
      logic [31:0] add_amount;
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [63:0] word3;
   } req_type;

   typedef struct packed {
      logic [63:0] write_addr;
      logic [63:0] beat0;
      logic [63:0] beat1;
      logic [63:0] beat2;
      logic [63:0] beat3;
      logic [1:0]  write_kind;
      logic [7:0]  resp_meta;
      logic [4:0]  resp_key_len;
      logic [63:0] resp_key0;
      logic [63:0] resp_key1;
      logic [63:0] resp_key2;
      logic [63:0] resp_key3;
   } rsp_type;

endpackage

// ===== sv/kvwp_value_fmt.sv =====
module kvwp_value_fmt import kvwp_pkg::*; (
   input  logic [3:0][63:0] words,
   input  logic [31:0]      add_amount,
   input  logic             straddle,
   input  logic             first_chunk,
   input  logic [15:0]      carry_in,
   output half_bytes_type   src,
   output logic [15:0]      carry_out
);

   logic [7:0][31:0] lane;
   logic [31:0]      sum;
   logic [15:0]      prev_half;
   half_bytes_type   vb;

   always_comb begin
      lane = '0;
      vb = '0;
      src = '0;
      prev_half = '0;
      sum = '0;
      for (int j = 0; j < 4; j++) begin
         prev_half = (j == 0) ? carry_in : words[(j + 3) % 4][15:0];
         if (straddle) begin
            lane[2*j]   = {prev_half, words[j][63:48]};
            lane[2*j+1] = words[j][47:16];
         end else begin
            lane[2*j]   = words[j][63:32];
            lane[2*j+1] = words[j][31:0];
         end
      end
      // first straddled chunk drops the leading half word (raw prefix)
      if (straddle && first_chunk) begin
         for (int j = 0; j < 7; j++) begin
            lane[j] = lane[j+1];
         end
      end
      for (int j = 0; j < 8; j++) begin
         sum = lane[j] + add_amount;
         vb[4*j]   = sum[31:24];
         vb[4*j+1] = sum[23:16];
         vb[4*j+2] = sum[15:8];
         vb[4*j+3] = sum[7:0];
      end
      if (straddle && first_chunk) begin
         src[0] = words[0][63:56];
         src[1] = words[0][55:48];
         for (int i = 0; i < 28; i++) begin
            src[i+2] = vb[i];
         end
      end else begin
         src = vb;
      end
   end

   assign carry_out = words[3][15:0];

endmodule

// ===== sv/kvwp_stage_merge.sv =====
module kvwp_stage_merge import kvwp_pkg::*; (
   input  half_bytes_type  held,
   input  half_bytes_type  src,
   input  logic [5:0]      fill,
   input  logic [5:0]      count,
   output stage_bytes_type merged
);

   logic [6:0] off;

   always_comb begin
      merged = '0;
      off = '0;
      for (int p = 0; p < STAGE_BYTES; p++) begin
         off = 7'(p) - {1'b0, fill};
         if ((7'(p) >= {1'b0, fill}) && (off < {1'b0, count})) begin
            merged[p] = src[off[4:0]];
         end else if (p < BEAT_BYTES) begin
            merged[p] = held[5'(p)];
         end
      end
   end

endmodule

// ===== sv/kv_record_write_packer_core.sv =====
// Channel   Dir  Handshake               Payload
// req_      in   req_valid / req_stall   req_data (req_type)
// rsp_      out  rsp_valid / rsp_stall   rsp_data (rsp_type)
//
// One transaction is taken per cycle when not stalled; results are registered
// and appear in the cycle after acceptance. A closing chunk or empty-value
// header yields two writes; the flush write waits in a second register.
// Input stalls while the flush register is full or the output register is held.
// Reset (synchronous, active high) clears all record state and both valid flags.
module kv_record_write_packer_core import kvwp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // record state
   logic [10:0]      bytes_left_ff, bytes_left_in;
   logic [7:0]       meta_ff, meta_in;
   logic [4:0]       key_len_ff, key_len_in;
   logic [3:0][63:0] key_ff, key_in;
   logic [63:0]      base_ff, base_in;
   logic [1:0]       mode_ff, mode_in;
   logic [31:0]      add_ff, add_in;
   half_bytes_type   stage_ff, stage_in;
   logic [5:0]       fill_ff, fill_in;
   logic [7:0]       count_ff, count_in;
   logic [15:0]      carry_ff, carry_in;

   // output registers
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    flush_valid_ff, flush_valid_in;
   rsp_type flush_ff, flush_in;

   logic             accept, out_take, is_header, straddle, first_chunk, last;
   logic [3:0][63:0] words;
   logic [4:0]       key_sat;
   logic [15:0]      size_word;
   stage_bytes_type  hdr, merged, emit;
   half_bytes_type   src;
   logic [15:0]      carry_next;
   logic [5:0]       put_count, fill_add;
   logic [6:0]       fill_sum;
   logic [10:0]      left;
   logic [1:0]       nres;
   logic [7:0]       cur_count;
   logic [63:0]      cur_base;
   logic [1:0]       cur_mode, cur_mode_raw;
   rsp_type          res0, res1;

   assign words = {req_data.word3, req_data.word2, req_data.word1, req_data.word0};
   assign is_header = (req_data.opcode == OP_HEADER);
   assign straddle = (mode_ff == MODE_FIRST);
   assign first_chunk = straddle && (count_ff == 8'd0);

   assign req_stall = flush_valid_ff | (out_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign out_take  = out_valid_ff & ~rsp_stall;

   kvwp_value_fmt u_fmt (
      .words       (words),
      .add_amount  (add_ff),
      .straddle    (straddle),
      .first_chunk (first_chunk),
      .carry_in    (carry_ff),
      .src         (src),
      .carry_out   (carry_next)
   );

   kvwp_stage_merge u_merge (
      .held   (stage_ff),
      .src    (src),
      .fill   (fill_ff),
      .count  (put_count),
      .merged (merged)
   );

   // header image: size word then the key, zero beyond
   always_comb begin
      key_sat = (req_data.key_len > 5'(KEY_MAX)) ? 5'(KEY_MAX) : req_data.key_len;
      size_word = {key_sat, req_data.value_len};
      hdr = '0;
      hdr[0] = size_word[15:8];
      hdr[1] = size_word[7:0];
      for (int j = 0; j < KEY_MAX; j++) begin
         if (5'(j) < key_sat) begin
            hdr[j+2] = words[j/8][63-8*(j%8) -: 8];
         end
      end
   end

   // byte counts for this chunk; the first straddled chunk places a raw prefix
   always_comb begin
      if (first_chunk) begin
         put_count = (bytes_left_ff >= 11'd32) ? 6'd32 :
                     (bytes_left_ff < 11'd2) ? 6'd2 : bytes_left_ff[5:0];
         fill_add  = (bytes_left_ff >= 11'd32) ? 6'd30 : bytes_left_ff[5:0];
         left      = (bytes_left_ff > 11'd32) ? bytes_left_ff - 11'd30 : 11'd0;
      end else begin
         put_count = (bytes_left_ff >= 11'd32) ? 6'd32 : bytes_left_ff[5:0];
         fill_add  = put_count;
         left      = (bytes_left_ff > 11'd32) ? bytes_left_ff - 11'd32 : 11'd0;
      end
      fill_sum = {1'b0, fill_ff} + {1'b0, fill_add};
      last = (left == 11'd0);
   end

   // results of this transaction
   always_comb begin
      cur_mode_raw = (req_data.array_mode == 2'd3) ? MODE_PLAIN : req_data.array_mode;
      cur_mode  = is_header ? cur_mode_raw : mode_ff;
      cur_base  = is_header ? req_data.record_base : base_ff;
      cur_count = is_header ? 8'd0 : count_ff;
      emit      = is_header ? hdr : merged;
      if (is_header) begin
         nres = (req_data.value_len == 11'd0) ? 2'd2 : 2'd0;
      end else if (bytes_left_ff == 11'd0) begin
         nres = 2'd0;
      end else begin
         nres = last ? 2'd2 : 2'd1;
      end

      res0 = '0;
      res0.write_addr = cur_base + {51'd0, cur_count, 5'd0};
      res0.write_kind = KIND_MORE;
      res1 = '0;
      res1.write_addr = cur_base + {51'd0, cur_count + 8'd1, 5'd0};
      for (int i = 0; i < 8; i++) begin
         res0.beat0[63-8*i -: 8] = emit[i];
         res0.beat1[63-8*i -: 8] = emit[8+i];
         res0.beat2[63-8*i -: 8] = emit[16+i];
         res0.beat3[63-8*i -: 8] = emit[24+i];
         res1.beat0[63-8*i -: 8] = emit[32+i];
         res1.beat1[63-8*i -: 8] = emit[40+i];
         res1.beat2[63-8*i -: 8] = emit[48+i];
         res1.beat3[63-8*i -: 8] = emit[56+i];
      end
      // flush carries the response unless the record continues an array
      if (cur_mode == MODE_CONT) begin
         res1.write_kind = KIND_LAST;
      end else begin
         res1.write_kind = KIND_RESP;
         res1.resp_meta    = is_header ? req_data.request_meta : meta_ff;
         res1.resp_key_len = is_header ? key_sat : key_len_ff;
         res1.resp_key0    = is_header ? req_data.word0 : key_ff[0];
         res1.resp_key1    = is_header ? req_data.word1 : key_ff[1];
         res1.resp_key2    = is_header ? req_data.word2 : key_ff[2];
         res1.resp_key3    = is_header ? req_data.word3 : key_ff[3];
      end
   end

   // next record state
   always_comb begin
      bytes_left_in = bytes_left_ff;
      meta_in       = meta_ff;
      key_len_in    = key_len_ff;
      key_in        = key_ff;
      base_in       = base_ff;
      mode_in       = mode_ff;
      add_in        = add_ff;
      stage_in      = stage_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      carry_in      = carry_ff;
      if (accept && is_header) begin
         // start a new record, abandon any open one
         bytes_left_in = req_data.value_len;
         meta_in       = req_data.request_meta;
         key_len_in    = key_sat;
         key_in        = words;
         base_in       = req_data.record_base;
         mode_in       = cur_mode_raw;
         add_in        = req_data.add_amount;
         stage_in      = hdr[BEAT_BYTES-1:0];
         fill_in       = (req_data.value_len == 11'd0) ? 6'd0 : 6'(key_sat) + 6'd2;
         count_in      = 8'd0;
         carry_in      = 16'd0;
      end else if (accept && bytes_left_ff != 11'd0) begin
         bytes_left_in = left;
         stage_in      = merged[STAGE_BYTES-1:BEAT_BYTES];
         fill_in       = (fill_sum > 7'd32) ? 6'(fill_sum - 7'd32) : 6'd0;
         count_in      = last ? 8'd0 : count_ff + 8'd1;
         if (straddle) begin
            carry_in = carry_next;
         end
      end
   end

   // output and flush registers
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      flush_valid_in = flush_valid_ff;
      flush_in       = flush_ff;
      if (accept && nres != 2'd0) begin
         out_valid_in   = 1'b1;
         out_in         = res0;
         flush_valid_in = (nres == 2'd2);
         flush_in       = res1;
      end else if (out_take) begin
         if (flush_valid_ff) begin
            out_in         = flush_ff;
            flush_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         meta_ff        <= '0;
         key_len_ff     <= '0;
         key_ff         <= '0;
         base_ff        <= '0;
         mode_ff        <= MODE_PLAIN;
         add_ff         <= '0;
         stage_ff       <= '0;
         fill_ff        <= '0;
         count_ff       <= '0;
         carry_ff       <= '0;
         out_valid_ff   <= 1'b0;
         flush_valid_ff <= 1'b0;
      end else begin
         bytes_left_ff  <= bytes_left_in;
         meta_ff        <= meta_in;
         key_len_ff     <= key_len_in;
         key_ff         <= key_in;
         base_ff        <= base_in;
         mode_ff        <= mode_in;
         add_ff         <= add_in;
         stage_ff       <= stage_in;
         fill_ff        <= fill_in;
         count_ff       <= count_in;
         carry_ff       <= carry_in;
         out_valid_ff   <= out_valid_in;
         flush_valid_ff <= flush_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      flush_ff <= flush_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== sv/kvwp_checker.sv =====
module kvwp_checker import kvwp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with output empty");

   a_more_has_no_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.write_kind == KIND_MORE) |->
      (rsp_data.resp_meta == 8'd0 && rsp_data.resp_key_len == 5'd0))
      else $error("response fields on a non-final write");

   a_key_len_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.resp_key_len <= 5'(KEY_MAX)))
      else $error("key length beyond saturation");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind kv_record_write_packer_core kvwp_checker u_kvwp_checker (.*);
